FILE: rtl/awr_pkg.sv
// awr_pkg: shared types, constants and helpers for the area-weighted resampler
// used by every module under rtl; no dependencies
package awr_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int SIDE_W      = 9;
  localparam int MAX_SIDE    = 256;
  localparam int COORD_W     = 8;
  localparam int CH_W        = 8;
  localparam int NUM_CH      = 4;
  localparam int IDX_W       = 16;
  localparam int STORE_DEPTH = 65536;
  localparam int ACC_W       = CH_W + FRAC_BITS;
  localparam int WGT_W       = FRAC_BITS + 1;
  localparam int SPAN_W      = 17;
  localparam int DIV_W       = SIDE_W + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_W);
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int CFG_IDX_W   = 3;

  localparam logic [ACC_W-1:0] ACC_CAP = ACC_W'(255) << FRAC_BITS;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_Y   = 3'd5;

  // item modes
  localparam logic MODE_ACCUM = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [CH_W-1:0]    red_in;
    logic [CH_W-1:0]    green_in;
    logic [CH_W-1:0]    blue_in;
    logic [CH_W-1:0]    alpha_in;
    logic [IDX_W-1:0]   dst_index;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]  red_out;
    logic [CH_W-1:0]  green_out;
    logic [CH_W-1:0]  blue_out;
    logic [CH_W-1:0]  alpha_out;
    logic [IDX_W-1:0] read_index;
  } out_item_t;

  typedef struct packed {
    logic [SIDE_W-1:0] src_width;
    logic [SIDE_W-1:0] src_height;
    logic [SIDE_W-1:0] dst_width;
    logic [SIDE_W-1:0] dst_height;
    logic              mirror_x;
    logic              mirror_y;
  } cfg_t;

  // classified command between front and back
  typedef struct packed {
    logic                         is_read;
    logic [COORD_W-1:0]           mx;
    logic [COORD_W-1:0]           my;
    logic [NUM_CH-1:0][CH_W-1:0]  ch;
    logic [IDX_W-1:0]             idx;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [SIDE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_W-1:0]  quot;
    logic [SIDE_W-1:0] rem;
  } div_resp_t;

  // side registers hold 1..MAX_SIDE
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v == '0) r = SIDE_W'(1);
    else if (v > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
    return r;
  endfunction

endpackage

FILE: rtl/awr_div.sv
// awr_div: restoring divider, one quotient bit per cycle
// depends on awr_pkg
module awr_div (
  input  logic              clk,
  input  logic              rst,
  input  awr_pkg::div_req_t  req,
  output awr_pkg::div_resp_t resp
);
  import awr_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     quot;
  logic [SIDE_W-1:0]    rem;
  logic [SIDE_W-1:0]    dvsr;
  logic [SIDE_W:0]      trial;
  logic                 qbit;

  // one trial subtract per cycle
  always_comb begin
    trial = {rem, quot[DIV_W-1]};
    qbit  = (trial >= {1'b0, dvsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      quot <= req.dividend;
      rem  <= '0;
      dvsr <= req.divisor;
    end else if (busy) begin
      quot <= {quot[DIV_W-2:0], qbit};
      rem  <= qbit ? SIDE_W'(trial - {1'b0, dvsr}) : trial[SIDE_W-1:0];
    end
  end

  assign resp.busy = busy;
  assign resp.done = done;
  assign resp.quot = quot;
  assign resp.rem  = rem;

endmodule

FILE: rtl/awr_front.sv
// awr_front: accepts input items, drops out-of-range accumulates, applies mirroring
// depends on awr_pkg
module awr_front (
  input  logic              clk,
  input  logic              rst,
  input  awr_pkg::cfg_t     cfg,
  input  logic              clearing,
  input  logic              in_valid,
  output logic              in_stall,
  input  awr_pkg::in_item_t in_data,
  output logic              push,
  output awr_pkg::cmd_t     push_cmd,
  input  logic              q_full
);
  import awr_pkg::*;

  logic   fv;
  cmd_t   fcmd;
  cmd_t   cmd_next;
  logic   keep;
  logic   accept;

  // classify the incoming item
  always_comb begin
    cmd_next.is_read = (in_data.mode == MODE_READ);
    cmd_next.mx = cfg.mirror_x ?
                  COORD_W'(cfg.src_width - SIDE_W'(1) - {1'b0, in_data.src_x}) : in_data.src_x;
    cmd_next.my = cfg.mirror_y ?
                  COORD_W'(cfg.src_height - SIDE_W'(1) - {1'b0, in_data.src_y}) : in_data.src_y;
    cmd_next.ch  = {in_data.alpha_in, in_data.blue_in, in_data.green_in, in_data.red_in};
    cmd_next.idx = in_data.dst_index;
    keep = cmd_next.is_read ||
           (({1'b0, in_data.src_x} < cfg.src_width) && ({1'b0, in_data.src_y} < cfg.src_height));
  end

  assign push     = fv && !q_full;
  assign push_cmd = fcmd;
  assign in_stall = clearing || (fv && q_full);
  assign accept   = in_valid && !in_stall;

  // one-entry holding stage
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else begin
      if (push) fv <= 1'b0;
      if (accept && keep) fv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) fcmd <= cmd_next;
  end

endmodule

FILE: rtl/awr_queue.sv
// awr_queue: short command fifo between front and back
// depends on awr_pkg
module awr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  awr_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output awr_pkg::cmd_t q_cmd
);
  import awr_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

endmodule

FILE: rtl/awr_back.sv
// awr_back: sequencer that walks destination spans and updates the accumulator store
// also serves reads, zeroing each entry read; depends on awr_pkg and awr_div
module awr_back (
  input  logic               clk,
  input  logic               rst,
  input  awr_pkg::cfg_t      cfg,
  output logic               clearing,
  input  logic               q_valid,
  input  awr_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output awr_pkg::out_item_t out_data
);
  import awr_pkg::*;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_SETUP  = 4'd2;
  localparam logic [3:0] ST_YDIV   = 4'd3;
  localparam logic [3:0] ST_YWAIT  = 4'd4;
  localparam logic [3:0] ST_YCHK   = 4'd5;
  localparam logic [3:0] ST_YWWAIT = 4'd6;
  localparam logic [3:0] ST_XDIV   = 4'd7;
  localparam logic [3:0] ST_XWAIT  = 4'd8;
  localparam logic [3:0] ST_XCHK   = 4'd9;
  localparam logic [3:0] ST_XWWAIT = 4'd10;
  localparam logic [3:0] ST_AREA   = 4'd11;
  localparam logic [3:0] ST_MUL    = 4'd12;
  localparam logic [3:0] ST_RMW    = 4'd13;
  localparam logic [3:0] ST_RDMEM  = 4'd14;
  localparam logic [3:0] ST_RDOUT  = 4'd15;

  logic [3:0] state;
  logic [3:0] state_next;

  cmd_t                        cmd;
  logic [IDX_W-1:0]            clr_addr;
  logic [SPAN_W-1:0]           s0y, s1y, d0y, s0x, s1x, d0x;
  logic [SIDE_W-1:0]           py, px;
  logic [WGT_W-1:0]            wy, wx, area;
  logic [2*WGT_W-1:0]          area_prod;
  logic [IDX_W-1:0]            idx;
  logic [NUM_CH-1:0][ACC_W-1:0] contrib;

  logic [NUM_CH*ACC_W-1:0]     mem [STORE_DEPTH];
  logic [NUM_CH*ACC_W-1:0]     rdata;
  logic                        we;
  logic [IDX_W-1:0]            waddr;
  logic [NUM_CH*ACC_W-1:0]     wdata;
  logic [NUM_CH*ACC_W-1:0]     sat_data;

  div_req_t  div_req;
  div_resp_t div_resp;

  logic              ycond, xcond, out_free;
  logic [SPAN_W-1:0] ylo, yhi, xlo, xhi, ovl_y, ovl_x, d0y_end, d0x_end;

  awr_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  assign clearing = (state == ST_CLEAR);
  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == ST_IDLE) && q_valid;

  // full-width product of the two axis weights
  assign area_prod = wx * wy;

  // overlap of the source span with the current destination pixel
  always_comb begin
    d0y_end = d0y + SPAN_W'(cfg.src_height);
    d0x_end = d0x + SPAN_W'(cfg.src_width);
    yhi   = (s1y < d0y_end) ? s1y : d0y_end;
    ylo   = (s0y > d0y) ? s0y : d0y;
    xhi   = (s1x < d0x_end) ? s1x : d0x_end;
    xlo   = (s0x > d0x) ? s0x : d0x;
    ovl_y = yhi - ylo;
    ovl_x = xhi - xlo;
    ycond = (d0y < s1y) && (py < cfg.dst_height);
    xcond = (d0x < s1x) && (px < cfg.dst_width);
  end

  // divider requests: span start, then per-pixel weights
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = cfg.src_height;
    unique case (state)
      ST_YDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(s0y);
      end
      ST_YCHK: begin
        div_req.start    = ycond;
        div_req.dividend = {ovl_y[SIDE_W-1:0], {FRAC_BITS{1'b0}}};
      end
      ST_XDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(s0x);
        div_req.divisor  = cfg.src_width;
      end
      ST_XCHK: begin
        div_req.start    = xcond;
        div_req.dividend = {ovl_x[SIDE_W-1:0], {FRAC_BITS{1'b0}}};
        div_req.divisor  = cfg.src_width;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // saturating add of the contributions
  always_comb begin
    logic [ACC_W:0] sum;
    sat_data = '0;
    sum = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      sum = {1'b0, rdata[c*ACC_W +: ACC_W]} + {1'b0, contrib[c]};
      sat_data[c*ACC_W +: ACC_W] = (sum > {1'b0, ACC_CAP}) ? ACC_CAP : sum[ACC_W-1:0];
    end
  end

  // store write port
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = '0;
    priority if (state == ST_CLEAR) begin
      we    = 1'b1;
      waddr = clr_addr;
    end else if (state == ST_RMW) begin
      we    = 1'b1;
      wdata = sat_data;
    end else if (state == ST_RDOUT) begin
      we = out_free;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[idx];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_addr == IDX_W'(STORE_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (q_valid) state_next = q_cmd.is_read ? ST_RDMEM : ST_SETUP;
      ST_SETUP:  state_next = ST_YDIV;
      ST_YDIV:   state_next = ST_YWAIT;
      ST_YWAIT:  if (div_resp.done) state_next = ST_YCHK;
      ST_YCHK:   state_next = ycond ? ST_YWWAIT : ST_IDLE;
      ST_YWWAIT: if (div_resp.done) state_next = ST_XDIV;
      ST_XDIV:   state_next = ST_XWAIT;
      ST_XWAIT:  if (div_resp.done) state_next = ST_XCHK;
      ST_XCHK:   state_next = xcond ? ST_XWWAIT : ST_YCHK;
      ST_XWWAIT: if (div_resp.done) state_next = ST_AREA;
      ST_AREA:   state_next = ST_MUL;
      ST_MUL:    state_next = ST_RMW;
      ST_RMW:    state_next = ST_XCHK;
      ST_RDMEM:  state_next = ST_RDOUT;
      ST_RDOUT:  if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
  end

  // span walk datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cmd <= q_cmd;
        idx <= q_cmd.idx;
      end
      ST_SETUP: begin
        s0y <= SPAN_W'(cmd.my * cfg.dst_height);
        s1y <= SPAN_W'(({1'b0, cmd.my} + SIDE_W'(1)) * cfg.dst_height);
        s0x <= SPAN_W'(cmd.mx * cfg.dst_width);
        s1x <= SPAN_W'(({1'b0, cmd.mx} + SIDE_W'(1)) * cfg.dst_width);
      end
      ST_YWAIT: if (div_resp.done) begin
        py  <= div_resp.quot[SIDE_W-1:0];
        d0y <= s0y - SPAN_W'(div_resp.rem);
      end
      ST_YWWAIT: if (div_resp.done) wy <= div_resp.quot[WGT_W-1:0];
      ST_XWAIT: if (div_resp.done) begin
        px  <= div_resp.quot[SIDE_W-1:0];
        d0x <= s0x - SPAN_W'(div_resp.rem);
      end
      ST_XCHK: if (!xcond) begin
        py  <= py + 1'b1;
        d0y <= d0y_end;
      end
      ST_XWWAIT: if (div_resp.done) wx <= div_resp.quot[WGT_W-1:0];
      ST_AREA: begin
        area <= area_prod[FRAC_BITS +: WGT_W];
        idx  <= IDX_W'(py * cfg.dst_width + SIDE_W'(px));
      end
      ST_MUL: begin
        for (int c = 0; c < NUM_CH; c++) contrib[c] <= ACC_W'(cmd.ch[c] * area);
      end
      ST_RMW: begin
        px  <= px + 1'b1;
        d0x <= d0x_end;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RDOUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RDOUT && out_free) begin
      out_data.red_out    <= rdata[0*ACC_W + FRAC_BITS +: CH_W];
      out_data.green_out  <= rdata[1*ACC_W + FRAC_BITS +: CH_W];
      out_data.blue_out   <= rdata[2*ACC_W + FRAC_BITS +: CH_W];
      out_data.alpha_out  <= rdata[3*ACC_W + FRAC_BITS +: CH_W];
      out_data.read_index <= idx;
    end
  end

  // checks
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_resp.busy)
    else $error("divider started while busy");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !q_pop)
    else $error("command taken during clearing pass");

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_XWWAIT && div_resp.done) |->
      (div_resp.quot <= (DIV_W'(1) << FRAC_BITS)))
    else $error("axis weight above one");

  a_pixel_inside: assert property (@(posedge clk) disable iff (rst)
    (state == ST_AREA) |-> (py < cfg.dst_height) && (px < cfg.dst_width))
    else $error("destination pixel outside image");

endmodule

FILE: rtl/area_weighted_image_resampler_unit.sv
// area_weighted_image_resampler_unit: top level, config registers, front, queue, back
// read item: front stage, queue, back-end command register, store read, output register
// accumulate item: back-end serial divisions for the row span start, each row's weight and
//   column span start, and each pixel's column weight, then area, multiply and store update
// items are carried out one at a time; the queue lets the front take up to 5 more meanwhile
// reset: synchronous; then a clearing pass over all 65536 store entries, no items taken
module area_weighted_image_resampler_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  awr_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output awr_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [awr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [awr_pkg::SIDE_W-1:0]          cfg_data
);
  import awr_pkg::*;

  cfg_t cfg;
  logic clearing;
  logic push, q_full, q_pop, q_valid;
  cmd_t push_cmd, q_cmd;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_width  <= SIDE_W'(1);
      cfg.src_height <= SIDE_W'(1);
      cfg.dst_width  <= SIDE_W'(1);
      cfg.dst_height <= SIDE_W'(1);
      cfg.mirror_x   <= 1'b0;
      cfg.mirror_y   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  cfg.src_width  <= clamp_side(cfg_data);
        REG_SRC_HEIGHT: cfg.src_height <= clamp_side(cfg_data);
        REG_DST_WIDTH:  cfg.dst_width  <= clamp_side(cfg_data);
        REG_DST_HEIGHT: cfg.dst_height <= clamp_side(cfg_data);
        REG_MIRROR_X:   cfg.mirror_x   <= cfg_data[0];
        REG_MIRROR_Y:   cfg.mirror_y   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  awr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .clearing (clearing),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  awr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  awr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .clearing  (clearing),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: verif/area_weighted_image_resampler_unit_test.sv
// area_weighted_image_resampler_unit_test: self-checking testbench for the area-weighted resampler
// depends on rtl/awr_pkg.sv and rtl/area_weighted_image_resampler_unit.sv
`timescale 1ns / 100ps

module area_weighted_image_resampler_unit_test;
  import awr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam int SETTLE_CYCLES = 20000;
  localparam int IN_W = $bits(in_item_t);
  localparam longint unsigned SAT_LIMIT = 64'd255 << FRAC_BITS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIDE_W-1:0] cfg_data = '0;

  area_weighted_image_resampler_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow of the block: registers and destination accumulators
  int unsigned sw_shadow = 1, sh_shadow = 1, dw_shadow = 1, dh_shadow = 1;
  bit mirx_shadow = 1'b0, miry_shadow = 1'b0;
  bit [ACC_W-1:0] pixel_acc [STORE_DEPTH][NUM_CH];
  out_item_t pending_reads [$];

  bit failed = 1'b0;
  bit calm = 1'b1;
  int recv_hold = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // overlap of source span m with destination pixel p as a 1.F weight
  function automatic longint unsigned span_weight(longint unsigned m, longint unsigned p,
                                                  longint unsigned sd, longint unsigned dd);
    longint unsigned s0, s1, d0, d1, lo, hi;
    s0 = m * dd;
    s1 = s0 + dd;
    d0 = p * sd;
    d1 = d0 + sd;
    lo = (s0 > d0) ? s0 : d0;
    hi = (s1 < d1) ? s1 : d1;
    if (hi <= lo) return 0;
    return ((hi - lo) << FRAC_BITS) / sd;
  endfunction

  function automatic int unsigned side_clamp(logic [SIDE_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return 32'(v);
  endfunction

  // spread one source pixel over the destination pixels it covers
  task automatic splat_pixel(in_item_t it);
    longint unsigned mx, my, x0, x1, y0, y1, wx, wy, area, sum, idx;
    longint unsigned ch [NUM_CH];
    if (it.src_x >= sw_shadow || it.src_y >= sh_shadow) return;
    ch[0] = 64'(it.red_in);
    ch[1] = 64'(it.green_in);
    ch[2] = 64'(it.blue_in);
    ch[3] = 64'(it.alpha_in);
    mx = mirx_shadow ? sw_shadow - 1 - it.src_x : it.src_x;
    my = miry_shadow ? sh_shadow - 1 - it.src_y : it.src_y;
    x0 = (mx * dw_shadow) / sw_shadow;
    x1 = ((mx + 1) * dw_shadow + sw_shadow - 1) / sw_shadow;
    y0 = (my * dh_shadow) / sh_shadow;
    y1 = ((my + 1) * dh_shadow + sh_shadow - 1) / sh_shadow;
    if (x1 > dw_shadow) x1 = dw_shadow;
    if (y1 > dh_shadow) y1 = dh_shadow;
    for (longint unsigned py = y0; py < y1; py++) begin
      wy = span_weight(my, py, sh_shadow, dh_shadow);
      for (longint unsigned px = x0; px < x1; px++) begin
        wx = span_weight(mx, px, sw_shadow, dw_shadow);
        area = (wx * wy) >> FRAC_BITS;
        idx = py * dw_shadow + px;
        if (idx >= STORE_DEPTH) continue;
        for (int c = 0; c < NUM_CH; c++) begin
          sum = pixel_acc[idx][c] + ch[c] * area;
          if (sum > SAT_LIMIT) sum = SAT_LIMIT;
          pixel_acc[idx][c] = ACC_W'(sum);
        end
      end
    end
  endtask

  // update the shadow for one accepted item
  task automatic predict_item(in_item_t it);
    out_item_t r;
    if (it.mode == MODE_ACCUM) begin
      splat_pixel(it);
    end else begin
      r.read_index = it.dst_index;
      r.red_out   = CH_W'(pixel_acc[it.dst_index][0] >> FRAC_BITS);
      r.green_out = CH_W'(pixel_acc[it.dst_index][1] >> FRAC_BITS);
      r.blue_out  = CH_W'(pixel_acc[it.dst_index][2] >> FRAC_BITS);
      r.alpha_out = CH_W'(pixel_acc[it.dst_index][3] >> FRAC_BITS);
      for (int c = 0; c < NUM_CH; c++) pixel_acc[it.dst_index][c] = '0;
      pending_reads.push_back(r);
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 60) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  // offer one item and wait until the block takes it
  task automatic send_item(in_item_t it);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(it);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic sender_idle();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIDE_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SRC_WIDTH:  sw_shadow = side_clamp(val);
      REG_SRC_HEIGHT: sh_shadow = side_clamp(val);
      REG_DST_WIDTH:  dw_shadow = side_clamp(val);
      REG_DST_HEIGHT: dh_shadow = side_clamp(val);
      REG_MIRROR_X:   mirx_shadow = val[0];
      REG_MIRROR_Y:   miry_shadow = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait for every read to come back, then let queued accumulates finish
  task automatic wait_idle();
    sender_idle();
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(int sw, int sh, int dw, int dh, bit mx, bit my);
    wait_idle();
    write_reg(REG_SRC_WIDTH, SIDE_W'(sw));
    write_reg(REG_SRC_HEIGHT, SIDE_W'(sh));
    write_reg(REG_DST_WIDTH, SIDE_W'(dw));
    write_reg(REG_DST_HEIGHT, SIDE_W'(dh));
    write_reg(REG_MIRROR_X, SIDE_W'(mx));
    write_reg(REG_MIRROR_Y, SIDE_W'(my));
  endtask

  function automatic in_item_t make_accum(int x, int y, int r, int g, int b, int a);
    in_item_t it;
    it = in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
    it.mode = MODE_ACCUM;
    it.src_x = COORD_W'(x);
    it.src_y = COORD_W'(y);
    it.red_in = CH_W'(r);
    it.green_in = CH_W'(g);
    it.blue_in = CH_W'(b);
    it.alpha_in = CH_W'(a);
    return it;
  endfunction

  function automatic in_item_t make_read(int idx);
    in_item_t it;
    it = in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
    it.mode = MODE_READ;
    it.dst_index = IDX_W'(idx);
    return it;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int unsigned pix;
    it = in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
    pix = dw_shadow * dh_shadow;
    if ($urandom_range(0, 99) < 68) begin
      it.mode = MODE_ACCUM;
      if ($urandom_range(0, 9) != 0) begin
        it.src_x = COORD_W'($urandom_range(0, sw_shadow - 1));
        it.src_y = COORD_W'($urandom_range(0, sh_shadow - 1));
      end
    end else begin
      it.mode = MODE_READ;
      if ($urandom_range(0, 9) < 8) it.dst_index = IDX_W'($urandom_range(0, pix - 1));
    end
    return it;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        failed = 1'b1;
      end else begin
        want = pending_reads.pop_front();
        if (out_data.red_out !== want.red_out) begin
          $display("%0t: red_out expected %0d got %0d", $time, want.red_out, out_data.red_out);
          failed = 1'b1;
        end
        if (out_data.green_out !== want.green_out) begin
          $display("%0t: green_out expected %0d got %0d", $time, want.green_out,
                   out_data.green_out);
          failed = 1'b1;
        end
        if (out_data.blue_out !== want.blue_out) begin
          $display("%0t: blue_out expected %0d got %0d", $time, want.blue_out, out_data.blue_out);
          failed = 1'b1;
        end
        if (out_data.alpha_out !== want.alpha_out) begin
          $display("%0t: alpha_out expected %0d got %0d", $time, want.alpha_out,
                   out_data.alpha_out);
          failed = 1'b1;
        end
        if (out_data.read_index !== want.read_index) begin
          $display("%0t: read_index expected %0d got %0d", $time, want.read_index,
                   out_data.read_index);
          failed = 1'b1;
        end
      end
    end
  end

  // receiver stall: random bursts, or a long counted hold when asked
  int stall_left = 0;
  always @(negedge clk) begin
    int r;
    if (recv_hold > 0) begin
      out_stall = 1'b1;
      recv_hold = recv_hold - 1;
    end else if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left = stall_left - 1;
    end else if (calm) begin
      out_stall = 1'b0;
    end else begin
      r = int'($urandom_range(0, 99));
      out_stall = 1'b0;
      if (r >= 65 && r < 95) stall_left = int'($urandom_range(1, 3));
      else if (r >= 95) stall_left = int'($urandom_range(10, 40));
    end
  end

  // reset values, clamping and spare register indexes
  task automatic test_registers();
    send_item(make_accum(0, 0, 200, 100, 50, 255));
    send_item(make_accum(1, 0, 255, 255, 255, 255));
    send_item(make_read(0));
    send_item(make_read(65535));
    wait_idle();
    write_reg(REG_SRC_WIDTH, 9'd0);
    write_reg(REG_SRC_HEIGHT, 9'd511);
    write_reg(REG_DST_WIDTH, 9'd511);
    write_reg(REG_DST_HEIGHT, 9'd0);
    write_reg(REG_SPARE_6, 9'd3);
    write_reg(REG_SPARE_7, 9'd511);
    send_item(make_accum(0, 255, 9, 8, 7, 6));
    send_item(make_accum(0, 0, 255, 0, 255, 0));
    send_item(make_read(0));
    send_item(make_read(255));
    send_item(make_read(65535));
  endtask

  // saturation, mirroring, extremes of the fields
  task automatic test_directed();
    set_geometry(4, 4, 4, 4, 0, 0);
    send_item(make_accum(3, 3, 255, 255, 255, 255));
    send_item(make_accum(3, 3, 255, 1, 0, 128));
    send_item(make_read(15));
    send_item(make_accum(0, 0, 0, 0, 0, 0));
    send_item(make_read(0));
    set_geometry(3, 2, 7, 5, 1, 1);
    send_item(make_accum(0, 0, 255, 128, 64, 1));
    send_item(make_accum(2, 1, 170, 85, 255, 255));
    for (int i = 0; i < 6; i++) send_item(make_read(i == 5 ? 34 : i * 7));
    send_item(make_read(35));
    set_geometry(256, 256, 1, 1, 0, 0);
    send_item(make_accum(255, 255, 255, 255, 255, 255));
    send_item(make_accum(128, 0, 255, 255, 255, 255));
    send_item(make_read(0));
  endtask

  task automatic test_random_phase(int sw, int sh, int dw, int dh, bit mx, bit my, int n);
    set_geometry(sw, sh, dw, dh, mx, my);
    calm = 1'b0;
    for (int i = 0; i < n; i++) begin
      calm = (i % 100) >= 80;
      send_item(rand_item());
    end
    calm = 1'b0;
  endtask

  // receiver holds off while reads keep coming, so the block stalls its input
  task automatic test_backpressure();
    set_geometry(16, 16, 16, 16, 0, 1);
    calm = 1'b1;
    recv_hold = 600;
    for (int i = 0; i < 40; i++) send_item(i % 3 == 0 ? rand_item() : make_read(i));
    calm = 1'b0;
  endtask

  // sender pauses until every expected result is back, then resumes
  task automatic test_pause();
    for (int i = 0; i < 30; i++) send_item(rand_item());
    sender_idle();
    while (pending_reads.size() != 0) @(posedge clk);
    for (int i = 0; i < 30; i++) send_item(rand_item());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_registers();
    test_directed();
    test_random_phase(256, 256, 256, 256, 1, 1, 260);
    test_random_phase(256, 256, 1, 1, 0, 0, 150);
    test_random_phase(3, 5, 7, 9, 1, 0, 200);
    test_random_phase(8, 8, 3, 3, 0, 1, 200);
    test_random_phase(1, 1, 1, 1, 0, 0, 100);
    test_random_phase(100, 60, 256, 150, 1, 1, 250);
    test_random_phase(256, 200, 128, 256, 0, 0, 250);
    test_random_phase(5, 4, 2, 11, 1, 1, 200);
    test_backpressure();
    test_pause();
    sender_idle();
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
